// File: hw/rtl/jdc_pkg.sv
// Shared types and constants for the Julian day to calendar converter.
// Used by every module of the block; depends on nothing.
package jdc_pkg;

  localparam int DAY_COUNT_BITS = 25;
  localparam int DAY_FIELD_W    = 25;
  localparam int SEC_W          = 17;
  localparam int NUM_STAGES     = 11;

  // day path widths
  localparam int X1_W = DAY_COUNT_BITS + 2;   // 4a - offset
  localparam int B_W  = X1_W - 17;            // century count
  localparam int C_W  = DAY_COUNT_BITS + 1;
  localparam int X2_W = DAY_COUNT_BITS + 7;   // 100c - offset
  localparam int D_W  = X2_W - 15;
  localparam int G_W  = 9;                    // day within shifted year
  localparam int F_W  = 4;
  localparam int F_K  = 23;

  localparam longint unsigned GREG_START = 64'd2299161;
  localparam longint unsigned B_OFS      = 64'd7468865;
  localparam longint unsigned B_DIV      = 64'd146097;
  localparam longint unsigned B_MUL      = (64'd1 << X1_W) / B_DIV;
  localparam longint unsigned D_OFS      = 64'd12210;
  localparam longint unsigned D_DIV      = 64'd36525;
  localparam longint unsigned D_MUL      = (64'd1 << X2_W) / D_DIV;
  localparam longint unsigned F_SCALE    = 64'd10000;
  localparam longint unsigned F_DIV      = 64'd306001;
  localparam longint unsigned FG_MUL     = F_SCALE * ((64'd1 << F_K) / F_DIV);
  localparam int              YEAR_OFS   = 4715;

  // time path
  localparam longint unsigned SEC_MAX    = 64'd86399;
  localparam int              H_K        = 17;
  localparam longint unsigned H_DIV      = 64'd3600;
  localparam longint unsigned H_MUL      = (64'd1 << H_K) / H_DIV;
  localparam int              M_K        = 12;
  localparam longint unsigned M_DIV      = 64'd60;
  localparam longint unsigned M_MUL      = (64'd1 << M_K) / M_DIV;

  localparam int MONTH_JAN = 1;
  localparam int MONTH_MAR = 3;

  typedef struct packed {
    logic [DAY_FIELD_W-1:0] day_count;
    logic [SEC_W-1:0]       seconds_of_day;
  } jdc_in_t;

  typedef struct packed {
    logic signed [17:0] cal_year;
    logic [3:0]         cal_month;
    logic [4:0]         cal_day;
    logic [4:0]         hour_of_day;
    logic [5:0]         minute_of_hour;
    logic [5:0]         second_of_minute;
  } jdc_out_t;

  typedef struct packed {
    logic enable;
  } jdc_ctrl_t;

  // floor(30.6001 * f)
  function automatic logic [G_W-1:0] jdc_month_base(input logic [F_W-1:0] f);
    logic [G_W-1:0] r;
    case (f)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      4'd15:   r = 9'd459;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/julian_day_to_calendar.sv
// Julian day number to calendar date and time of day, top level.
// Depends on jdc_pkg, jdc_date_pipe and jdc_time_pipe.
//
// Input channel: in_word_i carries a Julian day number (integer part of
// JD + 0.5) and the seconds since midnight; the word is taken at a clock
// edge with in_valid_i high and in_stall_o low. Output channel: out_word_o
// carries year, month, day, hour, minute and second; it is taken at an
// edge with out_valid_o high and out_stall_i low. Seconds above 86399 read
// as 23:59:59 on the same day.
// Days before 2299161 use the Julian calendar, later ones the Gregorian.
// out_valid_o comes from the last of 11 register stages, the first loaded at
// the accepting edge; one word per cycle is accepted while in_stall_o is low,
// set by the 11-stage datapath with a multiply in each division stage.
// Every stage advances together; while the output word is
// valid and stalled the whole pipeline holds and in_stall_o is high, so
// nothing is lost or repeated. With no valid output word the pipeline
// keeps moving and empty stages are filled.
// Reset clears all valid bits; the datapath registers are not reset.
module julian_day_to_calendar
  import jdc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  jdc_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output jdc_out_t out_word_o
);

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  jdc_ctrl_t             ctrl;

  assign ctrl.enable = !(valid_q[NUM_STAGES-1] && out_stall_i);
  assign in_stall_o  = !ctrl.enable;
  assign valid_d     = {valid_q[NUM_STAGES-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl.enable) begin
      valid_q <= valid_d;
    end
  end

  jdc_date_pipe u_date (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .day_i   (DAY_COUNT_BITS'(in_word_i.day_count)),
    .year_o  (out_word_o.cal_year),
    .month_o (out_word_o.cal_month),
    .dom_o   (out_word_o.cal_day)
  );

  jdc_time_pipe u_time (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .sec_i    (in_word_i.seconds_of_day),
    .hour_o   (out_word_o.hour_of_day),
    .minute_o (out_word_o.minute_of_hour),
    .second_o (out_word_o.second_of_minute)
  );

  assign out_valid_o = valid_q[NUM_STAGES-1];

endmodule

// File: hw/rtl/jdc_date_pipe.sv
// Eleven-stage date datapath: day number to year, month and day of month.
// Depends on jdc_pkg; constant divisions use reciprocal multiply and one correction.
module jdc_date_pipe
  import jdc_pkg::*;
(
  input  logic                      clk_i,
  input  jdc_ctrl_t                 ctrl_i,
  input  logic [DAY_COUNT_BITS-1:0] day_i,
  output logic signed [17:0]        year_o,
  output logic [3:0]                month_o,
  output logic [4:0]                dom_o
);

  localparam int BP_W = X1_W + B_W;
  localparam int DP_W = X2_W + D_W;
  localparam int FP_W = G_W + 19;

  // S1
  logic [DAY_COUNT_BITS-1:0] a1_q;
  logic                      greg1_q;
  logic [X1_W-1:0]           x1_1_q;
  // S2
  logic [DAY_COUNT_BITS-1:0] a2_q;
  logic                      greg2_q;
  logic [X1_W-1:0]           x1_2_q;
  logic [B_W-1:0]            b0_2_q;
  // S3
  logic [DAY_COUNT_BITS-1:0] a3_q;
  logic                      greg3_q;
  logic [B_W-1:0]            b3_q;
  // S4..S11
  logic [C_W-1:0]            c4_q, c5_q, c6_q, c7_q;
  logic [X2_W-1:0]           x2_5_q, x2_6_q;
  logic [D_W-1:0]            d0_6_q;
  logic [D_W-1:0]            d7_q, d8_q, d9_q, d10_q;
  logic [G_W-1:0]            g8_q, g9_q, g10_q;
  logic [F_W-1:0]            f0_9_q, f10_q;
  logic signed [17:0]        year_q;
  logic [3:0]                month_q;
  logic [4:0]                dom_q;

  logic [BP_W-1:0]   b_prod;
  logic [X1_W-1:0]   b_rem;
  logic [B_W-1:0]    b_d;
  logic [C_W-1:0]    c_d;
  logic [X2_W-1:0]   x2_d;
  logic [DP_W-1:0]   d_prod;
  logic [X2_W-1:0]   d_rem;
  logic [D_W-1:0]    d_d;
  logic [D_W+10:0]   e_prod;
  logic [C_W-1:0]    g_full;
  logic [FP_W-1:0]   f_prod;
  logic [F_K-1:0]    f_num;
  logic [F_K-1:0]    f_rem;
  logic [F_W-1:0]    f_d;
  logic [3:0]        month_d;
  logic [G_W-1:0]    dom_full;

  always_comb begin
    b_prod   = BP_W'(x1_1_q) * BP_W'(B_MUL);
    b_rem    = x1_2_q - X1_W'(b0_2_q * X1_W'(B_DIV));
    b_d      = (b_rem >= X1_W'(B_DIV)) ? b0_2_q + B_W'(1) : b0_2_q;
    if (greg3_q) begin
      c_d = C_W'(a3_q) + C_W'(b3_q) - C_W'(b3_q >> 2) + C_W'(1525);
    end else begin
      c_d = C_W'(a3_q) + C_W'(1524);
    end
    x2_d     = X2_W'(c4_q) * X2_W'(100) - X2_W'(D_OFS);
    d_prod   = DP_W'(x2_5_q) * DP_W'(D_MUL);
    d_rem    = x2_6_q - X2_W'(d0_6_q * X2_W'(D_DIV));
    d_d      = (d_rem >= X2_W'(D_DIV)) ? d0_6_q + D_W'(1) : d0_6_q;
    e_prod   = (D_W+11)'(d7_q) * (D_W+11)'(1461);
    g_full   = c7_q - C_W'(e_prod[D_W+10:2]);
    f_prod   = FP_W'(g8_q) * FP_W'(FG_MUL);
    f_num    = F_K'(g9_q) * F_K'(F_SCALE);
    f_rem    = f_num - F_K'(f0_9_q * F_K'(F_DIV));
    f_d      = (f_rem >= F_K'(F_DIV)) ? f0_9_q + F_W'(1) : f0_9_q;
    month_d  = (f10_q >= 4'd14) ? f10_q - 4'd13 : f10_q - 4'd1;
    dom_full = g10_q - jdc_month_base(f10_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.enable) begin
      a1_q    <= day_i;
      greg1_q <= (64'(day_i) >= GREG_START);
      x1_1_q  <= X1_W'({day_i, 2'b00}) - X1_W'(B_OFS);

      a2_q    <= a1_q;
      greg2_q <= greg1_q;
      x1_2_q  <= x1_1_q;
      b0_2_q  <= b_prod[X1_W+B_W-1:X1_W];

      a3_q    <= a2_q;
      greg3_q <= greg2_q;
      b3_q    <= b_d;

      c4_q    <= c_d;

      c5_q    <= c4_q;
      x2_5_q  <= x2_d;

      c6_q    <= c5_q;
      x2_6_q  <= x2_5_q;
      d0_6_q  <= d_prod[X2_W+D_W-1:X2_W];

      c7_q    <= c6_q;
      d7_q    <= d_d;

      d8_q    <= d7_q;
      g8_q    <= g_full[G_W-1:0];

      d9_q    <= d8_q;
      g9_q    <= g8_q;
      f0_9_q  <= f_prod[F_K+F_W-1:F_K];

      d10_q   <= d9_q;
      g10_q   <= g9_q;
      f10_q   <= f_d;

      year_q  <= $signed(18'(d10_q) - 18'(YEAR_OFS)
                 - ((month_d >= 4'(MONTH_MAR)) ? 18'd1 : 18'd0));
      month_q <= month_d;
      dom_q   <= dom_full[4:0];
    end
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign dom_o   = dom_q;

endmodule

// File: hw/rtl/jdc_time_pipe.sv
// Time-of-day datapath: seconds since midnight to hour, minute and second,
// delayed to match the date path. Depends on jdc_pkg.
module jdc_time_pipe
  import jdc_pkg::*;
(
  input  logic             clk_i,
  input  jdc_ctrl_t        ctrl_i,
  input  logic [SEC_W-1:0] sec_i,
  output logic [4:0]       hour_o,
  output logic [5:0]       minute_o,
  output logic [5:0]       second_o
);

  localparam int TIME_STAGES = 5;
  localparam int DLY = NUM_STAGES - TIME_STAGES;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  logic [SEC_W-1:0] s1_q, s2_q;
  logic [4:0]       h0_2_q, h3_q, h4_q;
  logic [11:0]      rem3_q, rem4_q;
  logic [5:0]       m0_4_q;
  hms_t             hms5_q;
  hms_t             dly_q [DLY];

  logic [SEC_W-1:0] s_sat;
  logic [22:0]      h_prod;
  logic [SEC_W-1:0] h_rem;
  logic [18:0]      m_prod;
  logic [11:0]      m_rem;
  hms_t             hms_d;

  always_comb begin
    s_sat  = (64'(sec_i) > SEC_MAX) ? SEC_W'(SEC_MAX) : sec_i;
    h_prod = 23'(s1_q) * 23'(H_MUL);
    h_rem  = s2_q - SEC_W'(h0_2_q * SEC_W'(H_DIV));
    m_prod = 19'(rem3_q) * 19'(M_MUL);
    m_rem  = rem4_q - 12'(m0_4_q * 12'(M_DIV));
    hms_d.hour = h4_q;
    if (m_rem >= 12'(M_DIV)) begin
      hms_d.minute = m0_4_q + 6'd1;
      hms_d.second = 6'(m_rem - 12'(M_DIV));
    end else begin
      hms_d.minute = m0_4_q;
      hms_d.second = 6'(m_rem);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.enable) begin
      s1_q   <= s_sat;
      s2_q   <= s1_q;
      h0_2_q <= h_prod[H_K+4:H_K];
      if (h_rem >= SEC_W'(H_DIV)) begin
        h3_q   <= h0_2_q + 5'd1;
        rem3_q <= 12'(h_rem - SEC_W'(H_DIV));
      end else begin
        h3_q   <= h0_2_q;
        rem3_q <= 12'(h_rem);
      end
      h4_q   <= h3_q;
      rem4_q <= rem3_q;
      m0_4_q <= m_prod[M_K+5:M_K];
      hms5_q <= hms_d;
      dly_q[0] <= hms5_q;
      for (int i = 1; i < DLY; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  assign hour_o   = dly_q[DLY-1].hour;
  assign minute_o = dly_q[DLY-1].minute;
  assign second_o = dly_q[DLY-1].second;

endmodule

// File: hw/rtl/jdc_checker.sv
// Port-level checks for julian_day_to_calendar, attached by bind.
// Depends on jdc_pkg.
module jdc_checker
  import jdc_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input jdc_in_t  in_word_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input jdc_out_t out_word_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("stalled input word changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output word");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.cal_month >= 4'(MONTH_JAN) && out_word_o.cal_month <= 4'd12
      && out_word_o.cal_day != 5'd0)
    else $error("date out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.hour_of_day <= 5'd23 && out_word_o.minute_of_hour <= 6'd59
      && out_word_o.second_of_minute <= 6'd59)
    else $error("time of day out of range");

endmodule

bind julian_day_to_calendar jdc_checker u_jdc_checker (.*);

// File: bench/testbench.sv
// Self-checking bench for julian_day_to_calendar: directed and random day numbers and times.
// A clocked driver and monitor check every output word against an in-bench date predictor.
// Depends on jdc_pkg and the julian_day_to_calendar RTL.
module testbench
  import jdc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned REFORM_JDN    = 64'd2299161;
  localparam longint unsigned LAST_SECOND   = 64'd86399;
  localparam longint unsigned MARCH         = 64'd3;
  localparam longint unsigned MONTH_WRAP    = 64'd14;
  localparam int              RANDOM_WORDS  = 700;
  localparam int              PACE_PHASES   = 4;
  localparam int              SETTLE_CYCLES = 40;
  localparam int              STALL_LIMIT   = 5000;
  localparam int              TX_IDLE_PCT[PACE_PHASES]  = '{0, 58, 0, 21};
  localparam int              RX_STALL_PCT[PACE_PHASES] = '{0, 0, 58, 21};

  typedef struct {
    jdc_in_t word;
    int      phase;
  } paced_word_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  jdc_in_t  in_word_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  jdc_out_t out_word_o;

  paced_word_t pending_words[$];
  jdc_out_t    expected_dates[$];
  int          pace_phase = 0;
  int          mismatches = 0;
  int          checked_words = 0;
  int          julian_days = 0;
  int          gregorian_days = 0;
  int          clipped_seconds = 0;
  int          idle_cycles = 0;

  julian_day_to_calendar i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #10 clk_i = ~clk_i;

  // Meeus conversion, all divisions as exact integer floors
  function automatic jdc_out_t jd_to_date_time(jdc_in_t w);
    longint unsigned jdn, cent, shifted, yr_days, yr_start, tail, mon_idx, mday, mon, secs;
    longint          yr;
    jdc_out_t        r;
    jdn = 64'(w.day_count) & ((64'd1 << DAY_COUNT_BITS) - 64'd1);
    if (jdn < REFORM_JDN) begin
      shifted = jdn + 64'd1524;
    end else begin
      cent    = (64'd4 * jdn - 64'd7468865) / 64'd146097;
      shifted = jdn + cent - cent / 64'd4 + 64'd1525;
    end
    yr_days  = (64'd100 * shifted - 64'd12210) / 64'd36525;
    yr_start = (64'd1461 * yr_days) / 64'd4;
    tail     = shifted - yr_start;
    mon_idx  = (64'd10000 * tail) / 64'd306001;
    mday     = tail - (64'd306001 * mon_idx) / 64'd10000;
    mon      = (mon_idx >= MONTH_WRAP) ? mon_idx - 64'd13 : mon_idx - 64'd1;
    yr       = longint'(yr_days) - 64'sd4715 - ((mon >= MARCH) ? 64'sd1 : 64'sd0);
    secs     = 64'(w.seconds_of_day);
    if (secs > LAST_SECOND) secs = LAST_SECOND;
    r.cal_year         = yr[17:0];
    r.cal_month        = mon[3:0];
    r.cal_day          = mday[4:0];
    r.hour_of_day      = 5'(secs / 64'd3600);
    r.minute_of_hour   = 6'((secs % 64'd3600) / 64'd60);
    r.second_of_minute = 6'(secs % 64'd60);
    return r;
  endfunction

  task automatic check_field(string fld, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fld, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_word(longint unsigned jdn, longint unsigned secs, int phase);
    paced_word_t p;
    p.word.day_count      = jdn[DAY_FIELD_W-1:0];
    p.word.seconds_of_day = secs[SEC_W-1:0];
    p.phase               = phase;
    pending_words.push_back(p);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_dates.push_back(jd_to_date_time(in_word_i));
        if (64'(in_word_i.day_count) < REFORM_JDN) julian_days++;
        else gregorian_days++;
        if (64'(in_word_i.seconds_of_day) > LAST_SECOND) clipped_seconds++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() > 0 &&
            $urandom_range(99) >= TX_IDLE_PCT[pending_words[0].phase]) begin
          in_valid_i <= 1'b1;
          in_word_i  <= pending_words[0].word;
          pace_phase <= pending_words[0].phase;
          pending_words.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_dates.size() == 0) begin
          $error("output word with nothing expected");
          mismatches++;
        end else begin
          check_field("cal_year", expected_dates[0].cal_year, out_word_o.cal_year);
          check_field("cal_month", expected_dates[0].cal_month, out_word_o.cal_month);
          check_field("cal_day", expected_dates[0].cal_day, out_word_o.cal_day);
          check_field("hour_of_day", expected_dates[0].hour_of_day, out_word_o.hour_of_day);
          check_field("minute_of_hour", expected_dates[0].minute_of_hour,
                      out_word_o.minute_of_hour);
          check_field("second_of_minute", expected_dates[0].second_of_minute,
                      out_word_o.second_of_minute);
          expected_dates.pop_front();
          checked_words++;
        end
      end
      out_stall_i <= ($urandom_range(99) < RX_STALL_PCT[pace_phase]);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $error("no handshake for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    longint unsigned jdn, secs;
    int              pick;

    // calendar edges, reform switch, leap rules, time extremes, clipped seconds
    queue_word(64'd0, 64'd0, 0);
    queue_word(64'd33554431, 64'd131071, 0);
    queue_word(64'd2299160, 64'd43200, 0);
    queue_word(64'd2299161, 64'd86399, 0);
    queue_word(64'd2451544, 64'd59, 0);
    queue_word(64'd2451545, 64'd60, 0);
    queue_word(64'd2451604, 64'd3599, 0);
    queue_word(64'd2451605, 64'd3600, 0);
    queue_word(64'd2415079, 64'd86400, 0);
    queue_word(64'd2415080, 64'd100000, 0);
    queue_word(64'd1721423, 64'd1, 0);
    queue_word(64'd1721424, 64'd61, 0);
    queue_word(64'd2305447, 64'd65535, 0);
    queue_word(64'd2460676, 64'd65536, 0);
    queue_word(64'd16777215, 64'd131070, 0);
    queue_word(64'd16777216, 64'd0, 0);
    queue_word(64'd2299159, 64'd86398, 0);
    queue_word(64'd2299162, 64'd7199, 0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(99);
      if (pick < 45)      jdn = $urandom_range(2600000, 1700000);
      else if (pick < 60) jdn = $urandom_range(2301161, 2297161);
      else if (pick < 75) jdn = $urandom_range(33554431, 0);
      else if (pick < 88) jdn = $urandom_range(1700000, 0);
      else                jdn = $urandom_range(33554431, 2600000);
      if ($urandom_range(99) < 85) secs = $urandom_range(86399, 0);
      else                         secs = $urandom_range(131071, 86400);
      queue_word(jdn, secs, n * PACE_PHASES / RANDOM_WORDS);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid_i || expected_dates.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Checked %0d output words: %0d Julian-calendar days, %0d Gregorian days,",
             checked_words, julian_days, gregorian_days);
    $display("%0d with clipped seconds, over %0d pacing phases.", clipped_seconds,
             PACE_PHASES);
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
